// ===== rtl/tlp_pkg.sv =====
// shared types and constants for the two-level local branch predictor
// no dependencies; used by every rtl file and the port checker
package tlp_pkg;

    localparam int HISTORY_ENTRIES_DEF = 512;
    localparam int PATTERN_TABLES_DEF  = 8;
    localparam int HISTORY_BITS_DEF    = 6;

    localparam int PC_BITS = 12;

    // front queue, power of two so the pointers wrap by themselves
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // request codes
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    // two-bit saturating counter codes
    localparam logic [1:0] CTR_MIN       = 2'b00;
    localparam logic [1:0] CTR_RESET     = 2'b01;
    localparam logic [1:0] CTR_TAKEN_MIN = 2'b10;
    localparam logic [1:0] CTR_MAX       = 2'b11;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } tlp_state_t;

    // back-end status seen by the front end
    typedef struct packed {
        logic clearing;
        logic take;
    } tlp_ctl_t;

endpackage

// ===== rtl/tlp_front.sv =====
// front end: accepts items, splits the branch address into table and history
// select over two stages, and buffers them in a small queue; uses tlp_pkg
module tlp_front #(
    parameter int HISTORY_ENTRIES = tlp_pkg::HISTORY_ENTRIES_DEF,
    parameter int PATTERN_TABLES  = tlp_pkg::PATTERN_TABLES_DEF,
    parameter int TW              = 1,
    parameter int HW              = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [tlp_pkg::PC_BITS-1:0] pc_low,
    input  logic                        taken,
    input  tlp_pkg::tlp_ctl_t           ctl,
    output logic                        q_valid,
    output logic                        q_req_type,
    output logic                        q_taken,
    output logic [TW-1:0]               q_table,
    output logic [HW-1:0]               q_hsel
);

    localparam int N  = tlp_pkg::PC_BITS;
    localparam int MW = N + 2;
    localparam int PW = 2 * N + 2;

    // exact quotients by reciprocal multiply: q = (pc * ceil(2^K / d)) >> K, K = N + clog2(d)
    localparam longint unsigned D1 = longint'(PATTERN_TABLES);
    localparam longint unsigned D2 = longint'(PATTERN_TABLES) * longint'(HISTORY_ENTRIES);
    localparam int K1 = N + $clog2(PATTERN_TABLES);
    localparam int K2 = N + $clog2(PATTERN_TABLES * HISTORY_ENTRIES);
    localparam longint unsigned M1 = ((64'd1 << K1) + D1 - 64'd1) / D1;
    localparam longint unsigned M2 = ((64'd1 << K2) + D2 - 64'd1) / D2;
    localparam logic [MW-1:0] M1_C = MW'(M1);
    localparam logic [MW-1:0] M2_C = MW'(M2);

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_req_reg;
    logic          s1_taken_reg;
    logic [N-1:0]  s1_pc_reg;
    logic [N-1:0]  s1_q1_reg;
    logic [N-1:0]  s1_q2_reg;

    logic [PW-1:0] prod1;
    logic [PW-1:0] prod2;
    logic [N-1:0]  q1;
    logic [N-1:0]  q2;

    logic [N-1:0]  table_full;
    logic [N:0]    hsel_full;

    logic          qe_req_reg   [tlp_pkg::QDEPTH];
    logic          qe_taken_reg [tlp_pkg::QDEPTH];
    logic [TW-1:0] qe_table_reg [tlp_pkg::QDEPTH];
    logic [HW-1:0] qe_hsel_reg  [tlp_pkg::QDEPTH];

    logic [tlp_pkg::QAW-1:0] head_reg, head_next;
    logic [tlp_pkg::QAW-1:0] tail_reg, tail_next;
    logic [tlp_pkg::QCW-1:0] cnt_reg, cnt_next;

    logic accept;

    // room is reserved for the item in the split stage as well
    assign full   = ctl.clearing
                  || ((cnt_reg + tlp_pkg::QCW'(s1_valid_reg)) >= tlp_pkg::QCW'(tlp_pkg::QDEPTH));
    assign accept = push && !full;

    assign prod1 = PW'(pc_low) * PW'(M1_C);
    assign prod2 = PW'(pc_low) * PW'(M2_C);
    assign q1    = N'(prod1 >> K1);
    assign q2    = N'(prod2 >> K2);

    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type;
            s1_taken_reg <= taken;
            s1_pc_reg    <= pc_low;
            s1_q1_reg    <= q1;
            s1_q2_reg    <= q2;
        end
    end

    // remainders from the registered quotients
    assign table_full = s1_pc_reg - N'(s1_q1_reg * N'(PATTERN_TABLES));
    assign hsel_full  = (N+1)'(s1_q1_reg) - (N+1)'((N+1)'(s1_q2_reg) * (N+1)'(HISTORY_ENTRIES));

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (s1_valid_reg)
        begin
            tail_next = tail_reg + tlp_pkg::QAW'(1);
        end
        if (ctl.take)
        begin
            head_next = head_reg + tlp_pkg::QAW'(1);
        end
        cnt_next = cnt_reg + tlp_pkg::QCW'(s1_valid_reg) - tlp_pkg::QCW'(ctl.take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            qe_req_reg[tail_reg]   <= s1_req_reg;
            qe_taken_reg[tail_reg] <= s1_taken_reg;
            qe_table_reg[tail_reg] <= table_full[TW-1:0];
            qe_hsel_reg[tail_reg]  <= hsel_full[HW-1:0];
        end
    end

    assign q_valid    = (cnt_reg != '0);
    assign q_req_type = qe_req_reg[head_reg];
    assign q_taken    = qe_taken_reg[head_reg];
    assign q_table    = qe_table_reg[head_reg];
    assign q_hsel     = qe_hsel_reg[head_reg];

endmodule

// ===== rtl/tlp_back.sv =====
// back end: history and counter memories, clearing sweep after reset,
// read-modify-write sequencer and result register; uses tlp_pkg
module tlp_back #(
    parameter int HISTORY_ENTRIES = tlp_pkg::HISTORY_ENTRIES_DEF,
    parameter int PATTERN_TABLES  = tlp_pkg::PATTERN_TABLES_DEF,
    parameter int HISTORY_BITS    = tlp_pkg::HISTORY_BITS_DEF,
    parameter int TW              = 1,
    parameter int HW              = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic              q_req_type,
    input  logic              q_taken,
    input  logic [TW-1:0]     q_table,
    input  logic [HW-1:0]     q_hsel,
    output tlp_pkg::tlp_ctl_t ctl,
    output logic              empty,
    input  logic              pop,
    output logic              predict_taken
);

    localparam int CTR_DEPTH = PATTERN_TABLES * (2 ** HISTORY_BITS);
    localparam int CA_W      = $clog2(CTR_DEPTH);
    localparam int CLR_DEPTH = (HISTORY_ENTRIES > CTR_DEPTH) ? HISTORY_ENTRIES : CTR_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int HB        = HISTORY_BITS;

    logic [HB-1:0] hist_mem [HISTORY_ENTRIES];
    logic [1:0]    ctr_mem  [CTR_DEPTH];

    tlp_pkg::tlp_state_t state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_taken_reg;

    logic                item_req_reg;
    logic                item_taken_reg;
    logic [TW-1:0]       item_table_reg;
    logic [HW-1:0]       item_hsel_reg;
    logic [HB-1:0]       hist_rd_reg;
    logic [1:0]          ctr_rd_reg;
    logic [CA_W-1:0]     ctr_addr_reg;

    logic                take;
    logic                ctr_re;
    logic                res_load;
    logic                hist_we;
    logic [HW-1:0]       hist_wa;
    logic [HB-1:0]       hist_wd;
    logic                ctr_we;
    logic [CA_W-1:0]     ctr_wa;
    logic [1:0]          ctr_wd;
    logic                out_free;
    logic                clr_last;
    logic                clr_in_hist;
    logic                clr_in_ctr;
    logic [CA_W-1:0]     ctr_addr;
    logic [1:0]          ctr_upd;
    logic                is_update;

    assign out_free    = !res_valid_reg || pop;
    assign clr_last    = (clr_reg == CLR_W'(CLR_DEPTH - 1));
    assign clr_in_hist = ({1'b0, clr_reg} < (CLR_W+1)'(HISTORY_ENTRIES));
    assign clr_in_ctr  = ({1'b0, clr_reg} < (CLR_W+1)'(CTR_DEPTH));
    assign ctr_addr    = (CA_W'(item_table_reg) << HB) | CA_W'(hist_rd_reg);
    assign is_update   = (item_req_reg == tlp_pkg::REQ_UPDATE);

    always_comb
    begin
        if (item_taken_reg)
        begin
            ctr_upd = (ctr_rd_reg == tlp_pkg::CTR_MAX) ? tlp_pkg::CTR_MAX : ctr_rd_reg + 2'd1;
        end
        else
        begin
            ctr_upd = (ctr_rd_reg == tlp_pkg::CTR_MIN) ? tlp_pkg::CTR_MIN : ctr_rd_reg - 2'd1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlp_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = tlp_pkg::ST_IDLE;
                end
            end
            tlp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = tlp_pkg::ST_HIST;
                end
            end
            tlp_pkg::ST_HIST:
            begin
                state_next = tlp_pkg::ST_CTR;
            end
            tlp_pkg::ST_CTR:
            begin
                if (out_free)
                begin
                    state_next = tlp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlp_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        take     = 1'b0;
        ctr_re   = 1'b0;
        res_load = 1'b0;
        hist_we  = 1'b0;
        hist_wa  = item_hsel_reg;
        hist_wd  = HB'({hist_rd_reg, item_taken_reg});
        ctr_we   = 1'b0;
        ctr_wa   = ctr_addr_reg;
        ctr_wd   = ctr_upd;
        clr_next = clr_reg;
        case (state_reg)
            tlp_pkg::ST_CLEAR:
            begin
                hist_we  = clr_in_hist;
                hist_wa  = clr_reg[HW-1:0];
                hist_wd  = '0;
                ctr_we   = clr_in_ctr;
                ctr_wa   = clr_reg[CA_W-1:0];
                ctr_wd   = tlp_pkg::CTR_RESET;
                clr_next = clr_reg + CLR_W'(1);
            end
            tlp_pkg::ST_IDLE:
            begin
                take = q_valid;
            end
            tlp_pkg::ST_HIST:
            begin
                ctr_re = 1'b1;
            end
            tlp_pkg::ST_CTR:
            begin
                res_load = out_free;
                hist_we  = out_free && is_update;
                ctr_we   = out_free && is_update;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_req_reg   <= q_req_type;
            item_taken_reg <= q_taken;
            item_table_reg <= q_table;
            item_hsel_reg  <= q_hsel;
        end
        if (ctr_re)
        begin
            ctr_addr_reg <= ctr_addr;
        end
        if (res_load)
        begin
            res_taken_reg <= (ctr_rd_reg >= tlp_pkg::CTR_TAKEN_MIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (take)
        begin
            hist_rd_reg <= hist_mem[q_hsel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            ctr_mem[ctr_wa] <= ctr_wd;
        end
        if (ctr_re)
        begin
            ctr_rd_reg <= ctr_mem[ctr_addr];
        end
    end

    assign ctl.clearing  = (state_reg == tlp_pkg::ST_CLEAR);
    assign ctl.take      = take;
    assign empty         = !res_valid_reg;
    assign predict_taken = res_taken_reg;

endmodule

// ===== rtl/two_level_local_branch_predictor.sv =====
// top level of the two-level local-history branch predictor
// instantiates tlp_front and tlp_back; uses tlp_pkg
//
// usage:
//   requests enter as a queue write: an item is taken on a clock edge with
//   push high and full low. req_type selects predict or update, pc_low is the
//   low branch address, taken is the resolved direction for an update.
//   results leave as a queue read: while empty is low, predict_taken holds the
//   oldest result (the counter as read before any update), taken on an edge
//   with pop high.
//   the back end works on one item at a time: the history read, the counter
//   read and the counter/history write-back are done in turn on the
//   single-port tables; the next item is taken once the last result is loaded.
//   reset: histories clear to zero and counters to weakly not taken through a
//   sweep of max(HISTORY_ENTRIES, PATTERN_TABLES * 2**HISTORY_BITS) words
//   (512 by default); full stays high until it ends.
//   stall: if pop stays low the result holds, the back end waits with the next
//   read-out, and up to five more items are buffered before full rises.
module two_level_local_branch_predictor #(
    parameter int HISTORY_ENTRIES = tlp_pkg::HISTORY_ENTRIES_DEF,
    parameter int PATTERN_TABLES  = tlp_pkg::PATTERN_TABLES_DEF,
    parameter int HISTORY_BITS    = tlp_pkg::HISTORY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [tlp_pkg::PC_BITS-1:0] pc_low,
    input  logic                        taken,
    output logic                        empty,
    input  logic                        pop,
    output logic                        predict_taken
);

    localparam int TW = (PATTERN_TABLES > 1) ? $clog2(PATTERN_TABLES) : 1;
    localparam int HW = $clog2(HISTORY_ENTRIES);

    tlp_pkg::tlp_ctl_t ctl;
    logic              q_valid;
    logic              q_req_type;
    logic              q_taken;
    logic [TW-1:0]     q_table;
    logic [HW-1:0]     q_hsel;

    tlp_front #(
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .PATTERN_TABLES  (PATTERN_TABLES),
        .TW              (TW),
        .HW              (HW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .pc_low     (pc_low),
        .taken      (taken),
        .ctl        (ctl),
        .q_valid    (q_valid),
        .q_req_type (q_req_type),
        .q_taken    (q_taken),
        .q_table    (q_table),
        .q_hsel     (q_hsel)
    );

    tlp_back #(
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .PATTERN_TABLES  (PATTERN_TABLES),
        .HISTORY_BITS    (HISTORY_BITS),
        .TW              (TW),
        .HW              (HW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_req_type    (q_req_type),
        .q_taken       (q_taken),
        .q_table       (q_table),
        .q_hsel        (q_hsel),
        .ctl           (ctl),
        .empty         (empty),
        .pop           (pop),
        .predict_taken (predict_taken)
    );

endmodule

// ===== rtl/tlp_checker.sv =====
// port-level checker for the branch predictor, bound to the top level
// depends on tlp_pkg and two_level_local_branch_predictor
module tlp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        req_type,
    input logic [tlp_pkg::PC_BITS-1:0] pc_low,
    input logic                        taken,
    input logic                        empty,
    input logic                        pop,
    input logic                        predict_taken
);

    logic [3:0] outst_reg, outst_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        outst_next = outst_reg + 4'(in_acc) - 4'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // a waiting result stays until taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(predict_taken))
        else $error("result changed while stalled");

    // a result only exists for an item that went in
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outst_reg != 4'd0))
        else $error("result without an accepted item");

    // buffering is bounded by the split stage, queue, back end and result slot
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= 4'(tlp_pkg::QDEPTH + 3))
        else $error("too many items in flight");

    // full is high as reset is released, so no item is taken as the table sweep starts
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full)
        else $error("item accepted during table clearing");

endmodule

bind two_level_local_branch_predictor tlp_checker u_tlp_checker (.*);

// ===== sim/two_level_local_branch_predictor_tb.sv =====
// testbench for the two-level local-history branch predictor
// drives requests through the push/full side, checks predict_taken on the pop/empty side
// depends on tlp_pkg and two_level_local_branch_predictor from the rtl folder
module two_level_local_branch_predictor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlp_pkg::*;

    localparam int N_HIST        = HISTORY_ENTRIES_DEF;
    localparam int N_TABLES      = PATTERN_TABLES_DEF;
    localparam int H_BITS        = HISTORY_BITS_DEF;
    localparam int N_COUNTERS    = N_TABLES * (1 << H_BITS);
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int ITEM_TARGET   = 1800;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 625000;
    localparam int N_HOT         = 16;
    localparam int N_ROWS        = 22;

    typedef enum int {
        PAT_ALWAYS,
        PAT_NEVER,
        PAT_ALTERNATE,
        PAT_LOOP,
        PAT_RANDOM
    } branch_pattern_t;

    // known = 1 when the expected direction is typed into the row
    typedef struct packed {
        logic               rq;
        logic [PC_BITS-1:0] pc;
        logic               tk;
        logic               known;
        logic               known_dir;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               req_type;
    logic [PC_BITS-1:0] pc_low;
    logic               taken;
    logic               empty;
    logic               pop;
    logic               predict_taken;

    logic [H_BITS-1:0]  local_hist [N_HIST];
    logic [1:0]         pattern_ctr [N_COUNTERS];
    logic               dir_expected_q [$];
    logic [PC_BITS-1:0] hot_pc [N_HOT];

    int items_sent    = 0;
    int errors        = 0;
    int hold_requests = 0;
    bit no_idle       = 1'b0;

    stim_row_t dir_rows [N_ROWS] = '{
        // fresh tables: every counter weakly not taken
        '{REQ_PREDICT, 12'd0,    1'b0, 1'b1, 1'b0},
        '{REQ_PREDICT, 12'd4095, 1'b1, 1'b1, 1'b0},
        '{REQ_UPDATE,  12'd4095, 1'b1, 1'b1, 1'b0},
        '{REQ_UPDATE,  12'd0,    1'b0, 1'b1, 1'b0},
        // counter now at its floor
        '{REQ_UPDATE,  12'd0,    1'b0, 1'b0, 1'b0},
        '{REQ_PREDICT, 12'd0,    1'b0, 1'b0, 1'b0},
        // always-taken branch: history fills with ones, counter saturates high
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b1, 1'b0, 1'b0},
        '{REQ_PREDICT, 12'd8,    1'b0, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd8,    1'b0, 1'b0, 1'b0},
        '{REQ_PREDICT, 12'd8,    1'b1, 1'b0, 1'b0},
        // same history entry, different pattern table
        '{REQ_PREDICT, 12'd9,    1'b0, 1'b0, 1'b0},
        '{REQ_UPDATE,  12'd4095, 1'b0, 1'b0, 1'b0},
        '{REQ_PREDICT, 12'd4095, 1'b0, 1'b0, 1'b0},
        '{REQ_PREDICT, 12'd2048, 1'b1, 1'b0, 1'b0}
    };

    two_level_local_branch_predictor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .pc_low        (pc_low),
        .taken         (taken),
        .empty         (empty),
        .pop           (pop),
        .predict_taken (predict_taken)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Verification failed");
        $finish;
    end

    // counter read before the update; update trains the counter then shifts the history
    function automatic logic lookup_and_train(logic rq, logic [PC_BITS-1:0] pc, logic tk);
        int         tbl;
        int         hsel;
        int         slot;
        logic [1:0] ctr;
        logic       dir;
        tbl  = pc % N_TABLES;
        hsel = (pc / N_TABLES) % N_HIST;
        slot = tbl * (1 << H_BITS) + local_hist[hsel];
        ctr  = pattern_ctr[slot];
        dir  = (ctr >= CTR_TAKEN_MIN);
        if (rq == REQ_UPDATE)
        begin
            if (tk && ctr != CTR_MAX)
                ctr = ctr + 2'd1;
            else if (!tk && ctr != CTR_MIN)
                ctr = ctr - 2'd1;
            pattern_ctr[slot] = ctr;
            local_hist[hsel]  = {local_hist[hsel][H_BITS-2:0], tk};
        end
        return dir;
    endfunction

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 24);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // known_ok selects a typed-in direction instead of the predicted one
    task automatic send_item(input logic rq, input logic [PC_BITS-1:0] pc, input logic tk,
                             input logic known_ok, input logic known_dir);
        int   gap;
        logic dir;
        gap = idle_len();
        @(negedge clk);
        repeat (gap)
        begin
            push     <= 1'b0;
            req_type <= 1'($urandom);
            pc_low   <= PC_BITS'($urandom);
            taken    <= 1'($urandom);
            @(negedge clk);
        end
        push     <= 1'b1;
        req_type <= rq;
        pc_low   <= pc;
        taken    <= tk;
        do
            @(posedge clk);
        while (full !== 1'b0);
        dir = lookup_and_train(rq, pc, tk);
        dir_expected_q.push_back(known_ok ? known_dir : dir);
        items_sent++;
    endtask

    // mostly trained branch streams from a small hot set, the rest raw noise
    task automatic run_random(input int upto);
        int              len;
        int              period;
        int              i;
        logic [PC_BITS-1:0] pc;
        logic            tk;
        branch_pattern_t kind;
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                pc     = hot_pc[$urandom_range(0, N_HOT - 1)];
                kind   = branch_pattern_t'($urandom_range(0, 4));
                len    = $urandom_range(4, 24);
                period = $urandom_range(2, 7);
                for (i = 0; i < len; i++)
                begin
                    case (kind)
                        PAT_ALWAYS:    tk = 1'b1;
                        PAT_NEVER:     tk = 1'b0;
                        PAT_ALTERNATE: tk = i[0];
                        PAT_LOOP:      tk = (i % period) != period - 1;
                        default:       tk = 1'($urandom);
                    endcase
                    if ($urandom_range(0, 1))
                        send_item(REQ_PREDICT, pc, 1'($urandom), 1'b0, 1'b0);
                    send_item(REQ_UPDATE, pc, tk, 1'b0, 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom), PC_BITS'($urandom), 1'($urandom), 1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n    = 1'b0;
        push     = 1'b0;
        req_type = REQ_PREDICT;
        pc_low   = '0;
        taken    = 1'b0;
        for (i = 0; i < N_HIST; i++)
            local_hist[i] = '0;
        for (i = 0; i < N_COUNTERS; i++)
            pattern_ctr[i] = CTR_RESET;
        // odd entries share the history entry of the one before, in another table
        for (i = 0; i < N_HOT; i += 2)
        begin
            hot_pc[i]     = (i == 0) ? PC_BITS'(0) :
                            (i == 2) ? '1 : PC_BITS'($urandom);
            hot_pc[i + 1] = hot_pc[i] ^ PC_BITS'($urandom_range(1, N_TABLES - 1));
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++)
            send_item(dir_rows[i].rq, dir_rows[i].pc, dir_rows[i].tk,
                      dir_rows[i].known, dir_rows[i].known_dir);

        run_random(600);
        no_idle = 1'b1;
        run_random(800);
        // receiver holds off while the sender keeps offering back to back
        hold_requests++;
        run_random(900);
        no_idle = 1'b0;
        run_random(ITEM_TARGET);

        @(negedge clk);
        push <= 1'b0;
        while (dir_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (dir_expected_q.size() == 0)
                report_mismatch($sformatf("result %0b with no item pending", predict_taken));
            else
            begin
                if (predict_taken !== dir_expected_q[0])
                    report_mismatch($sformatf("predict_taken %0b, expected %0b",
                                              predict_taken, dir_expected_q[0]));
                void'(dir_expected_q.pop_front());
            end
        end
    end

endmodule
